### sv/bal_pkg.sv
// Shared types, codes and helpers for the bounded array list.
package bal_pkg;

  // Sizing
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 4;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Action codes
  localparam logic [2:0] ACT_APPEND  = 3'd0;
  localparam logic [2:0] ACT_INSERT  = 3'd1;
  localparam logic [2:0] ACT_ERASE   = 3'd2;
  localparam logic [2:0] ACT_REVERSE = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Row commands
  localparam logic [2:0] RC_IDLE   = 3'd0;
  localparam logic [2:0] RC_INSERT = 3'd1;
  localparam logic [2:0] RC_ERASE  = 3'd2;
  localparam logic [2:0] RC_MIRROR = 3'd3;
  localparam logic [2:0] RC_SHIFT  = 3'd4;

  // Per-cell operations
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_LOAD   = 3'd1;
  localparam logic [2:0] CELL_LOWER  = 3'd2;
  localparam logic [2:0] CELL_UPPER  = 3'd3;
  localparam logic [2:0] CELL_MIRROR = 3'd4;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic [1:0]         error_code;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] idx;
  } row_cmd_t;

  typedef struct packed {
    logic [2:0] op;
  } cell_ctl_t;

  // Input value to stored width: truncate or sign extend
  function automatic value_t fit_in(logic signed [31:0] v);
    logic signed [63:0] e;
    e = v;
    return e[VALUE_WIDTH-1:0];
  endfunction

  // Stored value to the 32-bit result field
  function automatic logic [31:0] fit_out(value_t x);
    logic signed [VALUE_WIDTH-1:0] s;
    logic signed [63:0] e;
    s = x;
    e = s;
    return e[31:0];
  endfunction

  // Live count to the 5-bit result field
  function automatic logic [4:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

endpackage

### sv/bal_cell.sv
// One storage cell of the list row: holds an entry, or takes the load value, a neighbour's value or its mirror's.
module bal_cell import bal_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  value_t    load_val,
  input  value_t    lower_val,
  input  value_t    upper_val,
  input  value_t    mirror_val,
  output value_t    val_q
);

  value_t val_r;
  value_t val_nxt;

  // Source select
  always_comb begin
    unique case (ctl.op)
      CELL_LOAD:   val_nxt = load_val;
      CELL_LOWER:  val_nxt = lower_val;
      CELL_UPPER:  val_nxt = upper_val;
      CELL_MIRROR: val_nxt = mirror_val;
      default:     val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

### sv/bal_row.sv
// Row of list cells with neighbour and mirror wiring, per-cell decode and read select.
module bal_row import bal_pkg::*; (
  input  logic             clk,
  input  row_cmd_t         cmd,
  input  value_t           load_val,
  input  logic [IDX_W-1:0] rd_idx,
  output value_t           rd_val
);

  value_t    cell_q [CAPACITY];
  cell_ctl_t ctl    [CAPACITY];

  // Per-cell operation from the row command
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      unique case (cmd.kind)
        RC_INSERT: begin
          if (IDX_W'(i) > cmd.idx) ctl[i].op = CELL_LOWER;
          else if (IDX_W'(i) == cmd.idx) ctl[i].op = CELL_LOAD;
          else ctl[i].op = CELL_HOLD;
        end
        RC_ERASE: begin
          ctl[i].op = (IDX_W'(i) >= cmd.idx) ? CELL_UPPER : CELL_HOLD;
        end
        RC_MIRROR: ctl[i].op = CELL_MIRROR;
        RC_SHIFT:  ctl[i].op = CELL_UPPER;
        default:   ctl[i].op = CELL_HOLD;
      endcase
    end
  end

  // Cells; the ends take zero from beyond the row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t lower_v;
    value_t upper_v;
    if (g == 0) begin : g_lo_end
      assign lower_v = '0;
    end else begin : g_lo
      assign lower_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper_v = '0;
    end else begin : g_hi
      assign upper_v = cell_q[g+1];
    end
    bal_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .load_val   (load_val),
      .lower_val  (lower_v),
      .upper_val  (upper_v),
      .mirror_val (cell_q[CAPACITY-1-g]),
      .val_q      (cell_q[g])
    );
  end

  assign rd_val = cell_q[rd_idx];

endmodule

### sv/bounded_array_list.sv
// Top level of the bounded array list: beat handshake, action decode and result queue.
//
// A fixed-capacity ordered list of CAPACITY signed entries held in a row of register
// cells. Append, insert, erase, clear and read each finish in the cycle the beat is
// accepted, so these can be accepted back to back, one a cycle, while the result
// queue has room. Reverse of n entries (n of two or more) first mirrors the row end
// to end, then shifts it down one place a cycle until the live entries sit from index
// zero; no new beat is taken meanwhile. Every beat returns one result beat,
// produced at acceptance and held in a two-deep output queue, so one further input
// beat can be taken while a result waits. Input is stalled while reset is held.
// Reset clears only the live count, the shift counter and the handshake state; entry
// storage needs no clearing pass.
module bounded_array_list import bal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] shift_r, shift_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  out_beat_t        out_r, out_nxt;
  out_beat_t        skid_r, skid_nxt;

  logic             acc;
  logic             busy;
  logic             out_take;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] shift_load;
  logic [1:0]       res_err;
  logic [31:0]      res_rd;
  row_cmd_t         cmd_dec;
  row_cmd_t         row_cmd;
  value_t           row_rd;
  out_beat_t        res;

  assign busy     = (shift_r != '0);
  assign in_stall = busy || skid_valid_r || !rst_n;
  assign acc      = in_valid && !in_stall;
  assign pos_ext  = CMP_W'(in_data.position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Action decode
  always_comb begin
    res_err     = ERR_OK;
    res_rd      = '0;
    cnt_after   = count_r;
    shift_load  = '0;
    cmd_dec     = '{kind: RC_IDLE, idx: '0};
    unique case (in_data.action)
      ACT_APPEND: begin
        if (full) begin
          res_err = ERR_FULL;
        end else begin
          cmd_dec   = '{kind: RC_INSERT, idx: count_r[IDX_W-1:0]};
          cnt_after = count_r + CNT_W'(1);
        end
      end
      ACT_INSERT: begin
        if (full) begin
          res_err = ERR_FULL;
        end else if (pos_ext > cnt_ext) begin
          res_err = ERR_RANGE;
        end else begin
          cmd_dec   = '{kind: RC_INSERT, idx: pos_ext[IDX_W-1:0]};
          cnt_after = count_r + CNT_W'(1);
        end
      end
      ACT_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          res_err = ERR_RANGE;
        end else begin
          cmd_dec   = '{kind: RC_ERASE, idx: pos_ext[IDX_W-1:0]};
          cnt_after = count_r - CNT_W'(1);
        end
      end
      ACT_REVERSE: begin
        if (count_r >= CNT_W'(2)) begin
          cmd_dec    = '{kind: RC_MIRROR, idx: '0};
          shift_load = CNT_W'(CAPACITY) - count_r;
        end
      end
      ACT_CLEAR: cnt_after = '0;
      ACT_READ: begin
        if (pos_ext >= cnt_ext) res_err = ERR_RANGE;
        else res_rd = fit_out(row_rd);
      end
      default: ;
    endcase
    res = '{read_value: res_rd, entry_count: count_out(cnt_after), error_code: res_err};
  end

  // Row command: alignment shifts take priority
  always_comb begin
    if (busy) row_cmd = '{kind: RC_SHIFT, idx: '0};
    else if (acc) row_cmd = cmd_dec;
    else row_cmd = '{kind: RC_IDLE, idx: '0};
  end

  bal_row u_row (
    .clk      (clk),
    .cmd      (row_cmd),
    .load_val (fit_in(in_data.item_value)),
    .rd_idx   (pos_ext[IDX_W-1:0]),
    .rd_val   (row_rd)
  );

  // Count and shift counter
  always_comb begin
    count_nxt = acc ? cnt_after : count_r;
    if (busy) shift_nxt = shift_r - CNT_W'(1);
    else if (acc) shift_nxt = shift_load;
    else shift_nxt = '0;
  end

  // Two-deep result queue
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = acc;
      end
    end else if (acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      shift_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      shift_r      <= shift_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/bal_checker.sv
// Port-level checks for the bounded array list, bound to the top level.
module bal_checker import bal_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // Count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

  // A full error only ever comes with a full list
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code == ERR_FULL) |->
      (out_data.entry_count == 5'(CAPACITY)))
    else $error("full error with room left");

  // An accepted input beat has a result on offer the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat gave no result");

  // A stalled input beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input beat changed");

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind bounded_array_list bal_checker u_bal_checker (.*);
